// ----- rtl/core/thef_pkg.sv -----
package thef_pkg;

  localparam int unsigned STORE_BYTES_DEF = 4096;
  localparam int unsigned SEQ_MAX_DEF     = 32;
  localparam int unsigned READ_MAX_DEF    = 16;

  localparam logic [7:0] CH_ESC   = 8'h1b;
  localparam logic [7:0] CH_CAN   = 8'h18;
  localparam logic [7:0] CH_LBR   = 8'h5b;
  localparam logic [7:0] CH_QM    = 8'h3f;
  localparam logic [7:0] CH_GT    = 8'h3e;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_3     = 8'h33;
  localparam logic [7:0] CH_4     = 8'h34;
  localparam logic [7:0] CH_5     = 8'h35;
  localparam logic [7:0] CH_6     = 8'h36;
  localparam logic [7:0] CH_7     = 8'h37;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UB    = 8'h42;
  localparam logic [7:0] CH_UJ    = 8'h4a;
  localparam logic [7:0] CH_LC    = 8'h63;
  localparam logic [7:0] CH_LH    = 8'h68;
  localparam logic [7:0] CH_LL    = 8'h6c;
  localparam logic [7:0] CH_LN    = 8'h6e;
  localparam logic [7:0] CH_LQ    = 8'h71;
  localparam logic [7:0] FINAL_LO = 8'h40;
  localparam logic [7:0] FINAL_HI = 8'h7e;

  typedef struct packed {
    logic        kind;
    logic [7:0]  byte_value;
    logic [12:0] read_offset;
    logic [4:0]  read_length;
  } in_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        data_valid;
    logic        last;
    logic [13:0] total_length;
    logic        alt_active;
  } out_t;

endpackage

// ----- rtl/core/terminal_history_escape_filter.sv -----
// Channel   | Direction | Handshake               | Payload
// ----------+-----------+-------------------------+---------------------------
// item      | in        | start_i & !busy_o       | in_i  (kind, byte, offset, length)
// result    | out       | res_strobe_o, one cycle | res_o (byte, valid, last, totals)
//
// A terminal byte is decoded and then gives a result; a byte that is written
// into a ring goes through the push state first. Every byte taken inside a CSI
// sequence adds a check step, and a completed sequence that is kept is pushed
// byte by byte, up to SEQ_MAX bytes. A read returns its bytes one by one: each
// byte is one shared ring address computation and one registered RAM read.
// After the last result the block returns to idle, where it takes the next transfer.
// Each ring RAM has a single write port, one byte a cycle.
// Reset clears the parser, sequence count, flags and ring pointers; the ring
// RAMs themselves are not cleared. The receiver cannot stall: results go out
// on their strobe and are gone; busy_o holds off new items until the last one.
module terminal_history_escape_filter
  import thef_pkg::*;
#(
  parameter int unsigned STORE_BYTES = STORE_BYTES_DEF,
  parameter int unsigned SEQ_MAX     = SEQ_MAX_DEF,
  parameter int unsigned READ_MAX    = READ_MAX_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  in_t  in_i,
  output logic busy_o,
  output logic res_strobe_o,
  output out_t res_o
);

  localparam int unsigned AW     = $clog2(STORE_BYTES);
  localparam int unsigned CNT_W  = AW + 1;
  localparam int unsigned CW     = ((CNT_W > 14) ? CNT_W : 14) + 1;
  localparam int unsigned SQ_AW  = $clog2(SEQ_MAX);
  localparam int unsigned SQ_CW  = $clog2(SEQ_MAX + 1);
  localparam int unsigned RW     = $clog2(READ_MAX + 1);
  localparam int unsigned LW     = (RW > 5) ? RW : 5;
  localparam logic [CNT_W-1:0] SB_C   = CNT_W'(STORE_BYTES);
  localparam logic [SQ_CW-1:0] SEQ_C  = SQ_CW'(SEQ_MAX);
  localparam logic [LW-1:0]    RMAX_C = LW'(READ_MAX);

  typedef enum logic [2:0] {
    M_NORMAL = 3'd0,
    M_ESC    = 3'd1,
    M_CSI    = 3'd2,
    M_Z1     = 3'd3,
    M_Z2     = 3'd4,
    M_Z3     = 3'd5,
    M_ZM     = 3'd6
  } mode_e;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_PARSE  = 7'b0000010,
    S_CSI    = 7'b0000100,
    S_PUSH   = 7'b0001000,
    S_RESULT = 7'b0010000,
    S_RADDR  = 7'b0100000,
    S_RDATA  = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  mode_e  mode_q, mode_d;
  in_t    item_q;

  logic [7:0]       seq_q [SEQ_MAX];
  logic [SQ_CW-1:0] seq_cnt_q, seq_cnt_d;
  logic             seq_init, seq_we;

  logic             alt_q, alt_d;
  logic             set_alt_q, set_alt_d;
  logic [AW-1:0]    main_st_q, main_st_d, alt_st_q, alt_st_d;
  logic [CNT_W-1:0] main_cnt_q, main_cnt_d, alt_cnt_q, alt_cnt_d;

  logic [7:0]       pend_q [4];
  logic [7:0]       pend_d [4];
  logic [2:0]       pend_n_q, pend_n_d;
  logic             use_seq_q, use_seq_d;
  logic             tgt_alt_q, tgt_alt_d;
  logic [SQ_CW-1:0] idx_q, idx_d;

  logic             seg_q, seg_d;
  logic [CW-1:0]    seg_off_q, seg_off_d;
  logic [RW-1:0]    n_q, n_d, i_q, i_d;
  logic             rvalid_q, rvalid_d;

  // shared ring push arithmetic
  logic [CNT_W-1:0] p_cnt, p_cnt_new, p_offs, p_sum, p_tail;
  logic [AW-1:0]    p_st, p_st_new;
  logic             p_full;
  logic [7:0]       p_byte;
  logic [SQ_CW-1:0] p_total;

  // shared read address arithmetic
  logic [CNT_W-1:0] r_cnt, r_sum, r_addr;
  logic [AW-1:0]    r_st;
  logic [CW-1:0]    r_pos;
  logic             r_ok;
  logic [7:0]       main_rdata, alt_rdata;
  logic             last_rd;

  logic [7:0] b;
  logic       b_final, is_on, is_off, is_drop, is_clr;
  logic [LW-1:0] len_w;
  logic          seg_sel;

  assign b       = item_q.byte_value;
  assign b_final = (b >= FINAL_LO) && (b <= FINAL_HI);
  assign len_w   = LW'(item_q.read_length);
  assign seg_sel = alt_q && (CW'(item_q.read_offset) >= CW'(main_cnt_q));

  // Match finished sequences; entries 0 and 1 always hold ESC '['.
  assign is_on =
      (seq_cnt_q == SQ_CW'(8) && seq_q[2] == CH_QM && seq_q[3] == CH_1 &&
       seq_q[4] == CH_0 && seq_q[5] == CH_4 && seq_q[6] == CH_9 && seq_q[7] == CH_LH) ||
      (seq_cnt_q == SQ_CW'(6) && seq_q[2] == CH_QM && seq_q[3] == CH_4 &&
       seq_q[4] == CH_7 && seq_q[5] == CH_LH);
  assign is_off =
      (seq_cnt_q == SQ_CW'(8) && seq_q[2] == CH_QM && seq_q[3] == CH_1 &&
       seq_q[4] == CH_0 && seq_q[5] == CH_4 && seq_q[6] == CH_9 && seq_q[7] == CH_LL) ||
      (seq_cnt_q == SQ_CW'(6) && seq_q[2] == CH_QM && seq_q[3] == CH_4 &&
       seq_q[4] == CH_7 && seq_q[5] == CH_LL);
  assign is_drop =
      (b == CH_LC) ||
      (b == CH_LQ && seq_cnt_q >= SQ_CW'(3) && seq_q[2] == CH_GT) ||
      (seq_cnt_q == SQ_CW'(4) && seq_q[2] == CH_6 && seq_q[3] == CH_LN) ||
      (seq_cnt_q == SQ_CW'(4) && seq_q[2] == CH_5 && seq_q[3] == CH_LN);
  assign is_clr =
      seq_cnt_q == SQ_CW'(4) && seq_q[2] == CH_3 && seq_q[3] == CH_UJ;

  // Push one byte into the target ring, overwriting the oldest when full.
  always_comb begin
    p_cnt    = tgt_alt_q ? alt_cnt_q : main_cnt_q;
    p_st     = tgt_alt_q ? alt_st_q : main_st_q;
    p_full   = (p_cnt == SB_C);
    p_st_new = p_st;
    if (p_full) begin
      p_st_new = (p_st == AW'(STORE_BYTES - 1)) ? '0 : p_st + AW'(1);
    end
    p_offs    = p_full ? SB_C - CNT_W'(1) : p_cnt;
    p_cnt_new = p_full ? SB_C : p_cnt + CNT_W'(1);
    p_sum     = {1'b0, p_st_new} + p_offs;
    p_tail    = (p_sum >= SB_C) ? p_sum - SB_C : p_sum;
    p_byte    = use_seq_q ? seq_q[idx_q[SQ_AW-1:0]] : pend_q[idx_q[1:0]];
    p_total   = use_seq_q ? seq_cnt_q : SQ_CW'(pend_n_q);
  end

  // Address one history byte for the current read.
  always_comb begin
    r_cnt  = seg_q ? alt_cnt_q : main_cnt_q;
    r_st   = seg_q ? alt_st_q : main_st_q;
    r_pos  = seg_off_q + CW'(i_q);
    r_ok   = r_pos < CW'(r_cnt);
    r_sum  = {1'b0, r_st} + r_pos[CNT_W-1:0];
    r_addr = (r_sum >= SB_C) ? r_sum - SB_C : r_sum;
  end

  assign last_rd = ((RW + 1)'(i_q) + (RW + 1)'(1)) == (RW + 1)'(n_q);

  always_comb begin
    state_d    = state_q;
    mode_d     = mode_q;
    seq_cnt_d  = seq_cnt_q;
    seq_init   = 1'b0;
    seq_we     = 1'b0;
    alt_d      = alt_q;
    set_alt_d  = set_alt_q;
    main_st_d  = main_st_q;
    main_cnt_d = main_cnt_q;
    alt_st_d   = alt_st_q;
    alt_cnt_d  = alt_cnt_q;
    pend_d     = pend_q;
    pend_n_d   = pend_n_q;
    use_seq_d  = use_seq_q;
    tgt_alt_d  = tgt_alt_q;
    idx_d      = idx_q;
    seg_d      = seg_q;
    seg_off_d  = seg_off_q;
    n_d        = n_q;
    i_d        = i_q;
    rvalid_d   = rvalid_q;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          state_d = S_PARSE;
        end
      end

      S_PARSE: begin
        tgt_alt_d = alt_q;
        use_seq_d = 1'b0;
        idx_d     = '0;
        state_d   = S_RESULT;
        if (item_q.kind) begin
          if (item_q.read_length != 5'd0) begin
            n_d       = (len_w > RMAX_C) ? RW'(READ_MAX) : RW'(item_q.read_length);
            seg_d     = seg_sel;
            seg_off_d = CW'(item_q.read_offset) - (seg_sel ? CW'(main_cnt_q) : CW'(0));
            i_d       = '0;
            state_d   = S_RADDR;
          end
        end else begin
          unique case (mode_q)
            M_ESC: begin
              if (b == CH_LBR) begin
                mode_d    = M_CSI;
                seq_init  = 1'b1;
                seq_cnt_d = SQ_CW'(2);
              end else begin
                mode_d    = M_NORMAL;
                pend_d[0] = CH_ESC;
                pend_d[1] = b;
                pend_n_d  = 3'd2;
                state_d   = S_PUSH;
              end
            end
            M_CSI: begin
              seq_we    = 1'b1;
              seq_cnt_d = seq_cnt_q + SQ_CW'(1);
              state_d   = S_CSI;
            end
            M_Z1: begin
              if (b == CH_UB) begin
                mode_d = M_Z2;
              end else begin
                mode_d    = M_NORMAL;
                pend_d[0] = CH_CAN;
                pend_d[1] = b;
                pend_n_d  = 3'd2;
                state_d   = S_PUSH;
              end
            end
            M_Z2: begin
              if (b == CH_0) begin
                mode_d = M_Z3;
              end else begin
                mode_d    = M_NORMAL;
                pend_d[0] = CH_CAN;
                pend_d[1] = CH_UB;
                pend_d[2] = b;
                pend_n_d  = 3'd3;
                state_d   = S_PUSH;
              end
            end
            M_Z3: begin
              if (b == CH_0 || b == CH_1) begin
                mode_d = M_ZM;
              end else begin
                mode_d    = M_NORMAL;
                pend_d[0] = CH_CAN;
                pend_d[1] = CH_UB;
                pend_d[2] = CH_0;
                pend_d[3] = b;
                pend_n_d  = 3'd4;
                state_d   = S_PUSH;
              end
            end
            M_ZM: begin
              if (b == CH_ESC) begin
                mode_d = M_ESC;
              end
            end
            default: begin
              if (b == CH_ESC) begin
                mode_d = M_ESC;
              end else if (b == CH_CAN) begin
                mode_d = M_Z1;
              end else begin
                mode_d    = M_NORMAL;
                pend_d[0] = b;
                pend_n_d  = 3'd1;
                state_d   = S_PUSH;
              end
            end
          endcase
        end
      end

      S_CSI: begin
        use_seq_d = 1'b1;
        tgt_alt_d = alt_q;
        idx_d     = '0;
        if (seq_cnt_q >= SEQ_C) begin
          mode_d  = M_NORMAL;
          state_d = S_PUSH;
        end else if (!b_final) begin
          state_d = S_RESULT;
        end else begin
          mode_d  = M_NORMAL;
          state_d = S_PUSH;
          priority if (is_on) begin
            set_alt_d = 1'b1;
          end else if (is_off) begin
            alt_d     = 1'b0;
            alt_st_d  = '0;
            alt_cnt_d = '0;
            tgt_alt_d = 1'b0;
          end else if (is_drop) begin
            seq_cnt_d = '0;
            state_d   = S_RESULT;
          end else if (is_clr) begin
            if (alt_q) begin
              alt_st_d  = '0;
              alt_cnt_d = '0;
            end else begin
              main_st_d  = '0;
              main_cnt_d = '0;
            end
          end else begin
            set_alt_d = 1'b0;
          end
        end
      end

      S_PUSH: begin
        if (tgt_alt_q) begin
          alt_st_d  = p_st_new;
          alt_cnt_d = p_cnt_new;
        end else begin
          main_st_d  = p_st_new;
          main_cnt_d = p_cnt_new;
        end
        idx_d = idx_q + SQ_CW'(1);
        if (idx_q + SQ_CW'(1) == p_total) begin
          if (use_seq_q) begin
            seq_cnt_d = '0;
          end
          if (set_alt_q) begin
            alt_d     = 1'b1;
            set_alt_d = 1'b0;
          end
          state_d = S_RESULT;
        end
      end

      S_RESULT: begin
        state_d = S_IDLE;
      end

      S_RADDR: begin
        rvalid_d = r_ok;
        state_d  = S_RDATA;
      end

      S_RDATA: begin
        i_d     = i_q + RW'(1);
        state_d = last_rd ? S_IDLE : S_RADDR;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      mode_q     <= M_NORMAL;
      seq_cnt_q  <= '0;
      alt_q      <= 1'b0;
      set_alt_q  <= 1'b0;
      main_st_q  <= '0;
      main_cnt_q <= '0;
      alt_st_q   <= '0;
      alt_cnt_q  <= '0;
    end else begin
      state_q    <= state_d;
      mode_q     <= mode_d;
      seq_cnt_q  <= seq_cnt_d;
      alt_q      <= alt_d;
      set_alt_q  <= set_alt_d;
      main_st_q  <= main_st_d;
      main_cnt_q <= main_cnt_d;
      alt_st_q   <= alt_st_d;
      alt_cnt_q  <= alt_cnt_d;
    end
  end

  // Payload and work registers: no reset needed.
  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      item_q <= in_i;
    end
    if (seq_init) begin
      seq_q[0] <= CH_ESC;
      seq_q[1] <= CH_LBR;
    end else if (seq_we) begin
      seq_q[seq_cnt_q[SQ_AW-1:0]] <= b;
    end
    pend_q    <= pend_d;
    pend_n_q  <= pend_n_d;
    use_seq_q <= use_seq_d;
    tgt_alt_q <= tgt_alt_d;
    idx_q     <= idx_d;
    seg_q     <= seg_d;
    seg_off_q <= seg_off_d;
    n_q       <= n_d;
    i_q       <= i_d;
    rvalid_q  <= rvalid_d;
  end

  thef_ram #(
    .WIDTH(8),
    .DEPTH(STORE_BYTES)
  ) u_main_ram (
    .clk_i  (clk_i),
    .we_i   ((state_q == S_PUSH) && !tgt_alt_q),
    .waddr_i(p_tail[AW-1:0]),
    .wdata_i(p_byte),
    .re_i   (state_q == S_RADDR),
    .raddr_i(r_addr[AW-1:0]),
    .rdata_o(main_rdata)
  );

  thef_ram #(
    .WIDTH(8),
    .DEPTH(STORE_BYTES)
  ) u_alt_ram (
    .clk_i  (clk_i),
    .we_i   ((state_q == S_PUSH) && tgt_alt_q),
    .waddr_i(p_tail[AW-1:0]),
    .wdata_i(p_byte),
    .re_i   (state_q == S_RADDR),
    .raddr_i(r_addr[AW-1:0]),
    .rdata_o(alt_rdata)
  );

  // Drive the result transfer from the work registers.
  always_comb begin
    logic [CNT_W:0] total;
    total = (CNT_W + 1)'(main_cnt_q) + (alt_q ? (CNT_W + 1)'(alt_cnt_q) : '0);
    res_o.data_valid   = (state_q == S_RDATA) && rvalid_q;
    res_o.data_byte    = res_o.data_valid ? (seg_q ? alt_rdata : main_rdata) : 8'd0;
    res_o.last         = (state_q == S_RESULT) || last_rd;
    res_o.total_length = 14'(total);
    res_o.alt_active   = alt_q;
  end

  assign busy_o       = (state_q != S_IDLE);
  assign res_strobe_o = (state_q == S_RESULT) || (state_q == S_RDATA);

  a_strobe_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o |-> busy_o)
    else $error("result transfer outside an item");

  a_main_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (main_cnt_q <= SB_C) && (alt_cnt_q <= SB_C))
    else $error("ring fill count beyond store size");

  a_seq_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq_cnt_q <= SEQ_C)
    else $error("sequence count beyond limit");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && res_o.last) |=> !busy_o)
    else $error("still busy after final result");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted item did not start work");

endmodule

// ----- rtl/core/thef_ram.sv -----
module thef_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
